FILE: src/sed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, byte codes and helper functions for the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int BYTE_W  = 8;
  localparam int MAX_RES = 4;   // most bytes one item can produce
  localparam int CNT_W   = 3;   // holds 0..MAX_RES
  localparam int IDX_W   = 2;   // indexes 0..MAX_RES-1
  localparam int OCT_W   = 9;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // escape phase codes
  localparam logic [2:0] PH_PLAIN = 3'd0;
  localparam logic [2:0] PH_ESC   = 3'd1;
  localparam logic [2:0] PH_OCT1  = 3'd2;
  localparam logic [2:0] PH_OCT2  = 3'd3;
  localparam logic [2:0] PH_HEX0  = 3'd4;
  localparam logic [2:0] PH_HEX1  = 3'd5;

  // character codes
  localparam byte_t CH_NL     = 8'h0A;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_SQUOTE = 8'h27;
  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_LC_B   = 8'h62;
  localparam byte_t CH_LC_F   = 8'h66;
  localparam byte_t CH_LC_T   = 8'h74;
  localparam byte_t CH_LC_N   = 8'h6E;
  localparam byte_t CH_LC_R   = 8'h72;
  localparam byte_t CH_LC_V   = 8'h76;
  localparam byte_t CH_LC_A   = 8'h61;
  localparam byte_t CH_LC_X   = 8'h78;
  localparam byte_t CH_BS     = 8'h08;
  localparam byte_t CH_FF     = 8'h0C;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_VT     = 8'h0B;
  localparam byte_t CH_BEL    = 8'h07;

  localparam logic [4:0] NOT_HEX = 5'd16;

  function automatic logic is_oct(input byte_t c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  // hex digit value, NOT_HEX when the byte is no hex digit
  function automatic logic [4:0] hex_val(input byte_t c);
    logic [4:0] v;
    v = NOT_HEX;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      v = 5'(c[2:0]) + 5'd9;
    return v;
  endfunction

endpackage

FILE: src/string_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes backslash escapes in a string literal body, one byte per item.
// ----------------------------------------------------------------------------
// The first decoded byte of an item is read from the result register, which
//   is loaded from the input register.
// Throughput: one input item per cycle when each produces at most one byte
//   and m_tready is high; other items hold the result register until drained.
// Reset (rst, synchronous): both stages empty, escape phase back to plain.
module string_escape_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sed_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_char
  input  logic                       s_tlast,   // end_of_text
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sed_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_char
  output logic                       m_tlast    // run_last
);
  import sed_pkg::*;

  // input register
  logic  in_valid;
  byte_t in_char;
  logic  in_last;

  // decoder state
  logic [2:0]       phase, phase_next;
  logic [OCT_W-1:0] octal_value, octal_value_next;
  byte_t            held_hex, held_hex_next;

  // result register
  logic             rb_valid;
  byte_t            rb_data [MAX_RES];
  cnt_t             rb_cnt;
  logic [IDX_W-1:0] rb_idx;

  byte_t      res_bytes_next [MAX_RES];
  cnt_t       res_cnt_next;
  logic       plain_go;
  logic [4:0] hv_in, hv_held;

  logic out_take, out_end, rb_free, advance;

  assign hv_in   = hex_val(in_char);
  assign hv_held = hex_val(held_hex);

  always_comb begin
    phase_next       = phase;
    octal_value_next = octal_value;
    held_hex_next    = held_hex;
    res_bytes_next   = '{default: '0};
    res_cnt_next     = '0;
    plain_go         = 1'b0;

    unique case (phase)
      PH_ESC: begin
        phase_next = PH_PLAIN;
        unique case (in_char)
          CH_NL: ;
          CH_BSLASH, CH_SQUOTE, CH_DQUOTE: begin
            res_bytes_next[0] = in_char;
            res_cnt_next      = 3'd1;
          end
          CH_LC_B: begin res_bytes_next[0] = CH_BS;  res_cnt_next = 3'd1; end
          CH_LC_F: begin res_bytes_next[0] = CH_FF;  res_cnt_next = 3'd1; end
          CH_LC_T: begin res_bytes_next[0] = CH_TAB; res_cnt_next = 3'd1; end
          CH_LC_N: begin res_bytes_next[0] = CH_NL;  res_cnt_next = 3'd1; end
          CH_LC_R: begin res_bytes_next[0] = CH_CR;  res_cnt_next = 3'd1; end
          CH_LC_V: begin res_bytes_next[0] = CH_VT;  res_cnt_next = 3'd1; end
          CH_LC_A: begin res_bytes_next[0] = CH_BEL; res_cnt_next = 3'd1; end
          CH_LC_X: phase_next = PH_HEX0;
          default: begin
            if (is_oct(in_char)) begin
              octal_value_next = OCT_W'(in_char[2:0]);
              phase_next       = PH_OCT1;
            end else begin
              // unknown escape passes through with its backslash
              res_bytes_next[0] = CH_BSLASH;
              res_bytes_next[1] = in_char;
              res_cnt_next      = 3'd2;
            end
          end
        endcase
      end
      PH_OCT1: begin
        if (is_oct(in_char)) begin
          octal_value_next = {octal_value[5:0], in_char[2:0]};
          phase_next       = PH_OCT2;
        end else begin
          res_bytes_next[0] = octal_value[7:0];
          res_cnt_next      = 3'd1;
          phase_next        = PH_PLAIN;
          plain_go          = 1'b1;
        end
      end
      PH_OCT2: begin
        phase_next = PH_PLAIN;
        res_cnt_next = 3'd1;
        if (is_oct(in_char)) begin
          res_bytes_next[0] = {octal_value[4:0], in_char[2:0]};  // mod 256
        end else begin
          res_bytes_next[0] = octal_value[7:0];
          plain_go          = 1'b1;
        end
      end
      PH_HEX0: begin
        if (hv_in != NOT_HEX) begin
          held_hex_next = in_char;
          phase_next    = PH_HEX1;
        end else begin
          res_bytes_next[0] = CH_BSLASH;
          res_bytes_next[1] = CH_LC_X;
          res_cnt_next      = 3'd2;
          phase_next        = PH_PLAIN;
          plain_go          = 1'b1;
        end
      end
      PH_HEX1: begin
        phase_next = PH_PLAIN;
        if (hv_in != NOT_HEX) begin
          res_bytes_next[0] = {hv_held[3:0], hv_in[3:0]};
          res_cnt_next      = 3'd1;
        end else begin
          res_bytes_next[0] = CH_BSLASH;
          res_bytes_next[1] = CH_LC_X;
          res_bytes_next[2] = held_hex;
          res_cnt_next      = 3'd3;
          plain_go          = 1'b1;
        end
      end
      default: begin
        phase_next = PH_PLAIN;
        plain_go   = 1'b1;
      end
    endcase

    // byte reprocessed as ordinary text
    if (plain_go) begin
      if (in_char == CH_BSLASH) begin
        phase_next = PH_ESC;
      end else if (res_cnt_next != 3'(MAX_RES)) begin
        res_bytes_next[res_cnt_next[IDX_W-1:0]] = in_char;
        res_cnt_next = res_cnt_next + 3'd1;
      end
    end

    // end of text: flush pending escape, lone backslash is dropped
    if (in_last) begin
      unique case (phase_next)
        PH_OCT1, PH_OCT2: begin
          if (res_cnt_next != 3'(MAX_RES)) begin
            res_bytes_next[res_cnt_next[IDX_W-1:0]] = octal_value_next[7:0];
            res_cnt_next = res_cnt_next + 3'd1;
          end
        end
        PH_HEX0, PH_HEX1: begin
          if (res_cnt_next != 3'(MAX_RES)) begin
            res_bytes_next[res_cnt_next[IDX_W-1:0]] = CH_BSLASH;
            res_cnt_next = res_cnt_next + 3'd1;
          end
          if (res_cnt_next != 3'(MAX_RES)) begin
            res_bytes_next[res_cnt_next[IDX_W-1:0]] = CH_LC_X;
            res_cnt_next = res_cnt_next + 3'd1;
          end
          if (phase_next == PH_HEX1 && res_cnt_next != 3'(MAX_RES)) begin
            res_bytes_next[res_cnt_next[IDX_W-1:0]] = held_hex_next;
            res_cnt_next = res_cnt_next + 3'd1;
          end
        end
        default: ;
      endcase
      phase_next       = PH_PLAIN;
      octal_value_next = '0;
      held_hex_next    = '0;
    end
  end

  // handshake
  assign out_end  = ({1'b0, rb_idx} == rb_cnt - 3'd1);
  assign out_take = rb_valid && m_tready;
  assign rb_free  = !rb_valid || (m_tready && out_end);
  // an item with no output moves on even while the result register is busy
  assign advance  = in_valid && (rb_free || res_cnt_next == '0);
  assign s_tready = !in_valid || advance;

  assign m_tvalid = rb_valid;
  assign m_tdata  = rb_data[rb_idx];
  assign m_tlast  = out_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      rb_valid    <= 1'b0;
      rb_idx      <= '0;
      phase       <= PH_PLAIN;
      octal_value <= '0;
      held_hex    <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        phase       <= phase_next;
        octal_value <= octal_value_next;
        held_hex    <= held_hex_next;
      end

      if (advance && res_cnt_next != '0) begin
        rb_valid <= 1'b1;
        rb_idx   <= '0;
      end else if (out_take) begin
        if (out_end) rb_valid <= 1'b0;
        else         rb_idx   <= rb_idx + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
    if (advance && res_cnt_next != '0) begin
      rb_data <= res_bytes_next;
      rb_cnt  <= res_cnt_next;
    end
  end

endmodule

FILE: src/sed_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks for the string escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sed_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [sed_pkg::BYTE_W-1:0] m_tdata,
  input logic                       m_tlast
);
  import sed_pkg::*;

  // bytes taken since the last end of run
  logic [IDX_W-1:0] run_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (m_tvalid && m_tready) begin
      run_cnt <= m_tlast ? '0 : run_cnt + 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output item changed");

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && run_cnt == IDX_W'(MAX_RES - 1) |-> m_tlast)
    else $error("more than four bytes for one input item");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (.*);
